FILE: sv/tcw_pkg.sv
// tcw_pkg: shared types, constants and helpers for the text console cell writer.
// Depends on nothing; used by tcw_front, tcw_back and the top level.
package tcw_pkg;

  localparam int COLS = 80;
  localparam int ROWS = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;

  // Small queues between and after the two halves.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] BLANK_CHAR     = 8'h20;
  localparam logic [7:0] BACKSPACE_CHAR = 8'h08;
  localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [7:0] TEXT_COLOR_RST = 8'h0F;

  typedef enum logic [1:0] {
    REQ_CHAR  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_AT    = 2'd2,
    REQ_EOS   = 2'd3
  } req_code_t;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_BS,
    OP_NL,
    OP_CLEAR,
    OP_AT,
    OP_DROP,
    OP_EOS
  } op_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       char_code;
    logic [COL_W-1:0] at_col;
    logic [ROW_W-1:0] at_row;
    logic [7:0]       at_color;
  } req_t;

  typedef struct packed {
    logic              cell_write;
    logic              fill_all;
    logic [ADDR_W-1:0] cell_index;
    logic [15:0]       cell_value;
    logic              cursor_valid;
    logic [ADDR_W-1:0] cursor_pos;
  } res_t;

  // Classified command handed from front to back.
  typedef struct packed {
    op_t              op;
    logic [7:0]       ch;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       color;
  } cmd_t;

  // Linear cell address, row * COLS + col, kept to the address width.
  function automatic logic [ADDR_W-1:0] lin_addr(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
    logic [ADDR_W+COL_W:0] prod;
    prod = (ADDR_W+COL_W+1)'(row) * (ADDR_W+COL_W+1)'(COLS)
         + (ADDR_W+COL_W+1)'(col);
    return prod[ADDR_W-1:0];
  endfunction

endpackage

FILE: sv/text_console_cell_writer_top.sv
// text_console_cell_writer_top: text console cell writer, front and back halves.
// Depends on tcw_pkg, tcw_front and tcw_back.
//
//   channel   handshake          payload          notes
//   request   push / full        req   (req_t)    taken when push && !full
//   result    empty / pop        res   (res_t)    oldest result shown while !empty
//   config    cfg_we             cfg_wdata [7:0]  text color, written when cfg_we
//
// One item per cycle sustained while results are popped; a taken item is registered
// in the front queue, executes out of it into the result queue, and is then shown
// on the result ports, from where it can be popped.
// The cursor update plus row*COLS+col address is the registered loop in the back.
// rst (synchronous) homes the cursor, sets text color to 0x0F, empties both queues.
// A stalled result side fills the result queue, then the command queue, then full
// rises; each queue holds four items.
module text_console_cell_writer_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  tcw_pkg::req_t req,
  output logic          empty,
  input  logic          pop,
  output tcw_pkg::res_t res,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata
);

  // Command path between the halves.
  logic          cmd_valid;
  logic          cmd_pop;
  tcw_pkg::cmd_t cmd;

  // Front: accept, classify (char/backspace/newline, on/off-screen), queue.
  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back: cursor, text color, cell addressing, result queue.
  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

endmodule

FILE: sv/tcw_front.sv
// tcw_front: accepts requests, classifies them into commands, queues them.
// Depends on tcw_pkg.
module tcw_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  tcw_pkg::req_t req,
  output logic          cmd_valid,
  output tcw_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  localparam int COL_CMP = tcw_pkg::COL_W + 2;
  localparam int ROW_CMP = tcw_pkg::ROW_W + 2;

  tcw_pkg::cmd_t                q [tcw_pkg::QDEPTH];
  logic [tcw_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tcw_pkg::QPTR_W:0]     count;
  tcw_pkg::cmd_t                cls;
  logic                         do_push;
  logic                         do_pop;

  assign full      = (count == (tcw_pkg::QPTR_W+1)'(tcw_pkg::QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Classify the request.
  always_comb begin
    cls.ch    = req.char_code;
    cls.col   = req.at_col;
    cls.row   = req.at_row;
    cls.color = req.at_color;
    case (tcw_pkg::req_code_t'(req.req_type))
      tcw_pkg::REQ_CHAR: begin
        if (req.char_code == tcw_pkg::BACKSPACE_CHAR) begin
          cls.op = tcw_pkg::OP_BS;
        end else if (req.char_code == tcw_pkg::NEWLINE_CHAR) begin
          cls.op = tcw_pkg::OP_NL;
        end else begin
          cls.op = tcw_pkg::OP_PUT;
        end
      end
      tcw_pkg::REQ_CLEAR: cls.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::REQ_AT: begin
        if ((COL_CMP'(req.at_col) < COL_CMP'(tcw_pkg::COLS)) &&
            (ROW_CMP'(req.at_row) < ROW_CMP'(tcw_pkg::ROWS))) begin
          cls.op = tcw_pkg::OP_AT;
        end else begin
          cls.op = tcw_pkg::OP_DROP;
        end
      end
      default: cls.op = tcw_pkg::OP_EOS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (tcw_pkg::QPTR_W+1)'(do_push) - (tcw_pkg::QPTR_W+1)'(do_pop);
    end
  end

  // Occupancy stays within the queue.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= (tcw_pkg::QPTR_W+1)'(tcw_pkg::QDEPTH))
    else $error("front queue over depth");

  // Pointer distance matches occupancy.
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[tcw_pkg::QPTR_W-1:0])
    else $error("front queue pointers out of step");

  // An item taken into an empty queue is offered to the back next cycle.
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !cmd_valid) |=> cmd_valid)
    else $error("front queue lost an item");

endmodule

FILE: sv/tcw_back.sv
// tcw_back: executes commands against the cursor and queues result items.
// Depends on tcw_pkg.
module tcw_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  input  logic          cmd_valid,
  input  tcw_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          empty,
  input  logic          pop,
  output tcw_pkg::res_t res
);

  localparam int CW = tcw_pkg::COL_W + 1;
  localparam int RW = tcw_pkg::ROW_W + 1;

  logic [7:0]                   text_color;
  logic [tcw_pkg::COL_W-1:0]    cursor_col;
  logic [tcw_pkg::ROW_W-1:0]    cursor_row;
  logic [tcw_pkg::COL_W-1:0]    cursor_col_next;
  logic [tcw_pkg::ROW_W-1:0]    cursor_row_next;
  logic [CW-1:0]                col_inc;
  logic [RW-1:0]                row_inc;
  logic [tcw_pkg::ROW_W-1:0]    row_wrap;
  tcw_pkg::res_t                r;

  tcw_pkg::res_t                q [tcw_pkg::QDEPTH];
  logic [tcw_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tcw_pkg::QPTR_W:0]     count;
  logic                         q_full;
  logic                         do_pop;

  assign q_full  = (count == (tcw_pkg::QPTR_W+1)'(tcw_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign res     = q[rd_ptr];
  assign cmd_pop = cmd_valid && !q_full;
  assign do_pop  = pop && !empty;

  assign col_inc  = CW'(cursor_col) + 1'b1;
  assign row_inc  = RW'(cursor_row) + 1'b1;
  assign row_wrap = (row_inc >= RW'(tcw_pkg::ROWS)) ? '0 : row_inc[tcw_pkg::ROW_W-1:0];

  always_comb begin
    r               = '0;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    case (cmd.op)
      tcw_pkg::OP_PUT: begin
        r.cell_write = 1'b1;
        r.cell_index = tcw_pkg::lin_addr(cursor_col, cursor_row);
        r.cell_value = {text_color, cmd.ch};
        if (col_inc >= CW'(tcw_pkg::COLS)) begin
          cursor_col_next = '0;
          cursor_row_next = row_wrap;
        end else begin
          cursor_col_next = col_inc[tcw_pkg::COL_W-1:0];
        end
      end
      tcw_pkg::OP_BS: begin
        if (cursor_col != '0) begin
          cursor_col_next = cursor_col - 1'b1;
        end else if (cursor_row != '0) begin
          cursor_col_next = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
          cursor_row_next = cursor_row - 1'b1;
        end
        r.cell_write = 1'b1;
        r.cell_index = tcw_pkg::lin_addr(cursor_col_next, cursor_row_next);
        r.cell_value = {text_color, tcw_pkg::BLANK_CHAR};
      end
      tcw_pkg::OP_NL: begin
        cursor_col_next = '0;
        cursor_row_next = row_wrap;
      end
      tcw_pkg::OP_CLEAR: begin
        r.fill_all      = 1'b1;
        r.cell_value    = {text_color, tcw_pkg::BLANK_CHAR};
        cursor_col_next = '0;
        cursor_row_next = '0;
      end
      tcw_pkg::OP_AT: begin
        r.cell_write = 1'b1;
        r.cell_index = tcw_pkg::lin_addr(cmd.col, cmd.row);
        r.cell_value = {cmd.color, cmd.ch};
      end
      tcw_pkg::OP_EOS: begin
        r.cursor_valid = 1'b1;
        r.cursor_pos   = tcw_pkg::lin_addr(cursor_col, cursor_row);
      end
      default: r = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      q[wr_ptr] <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcw_pkg::TEXT_COLOR_RST;
      cursor_col <= '0;
      cursor_row <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (cfg_we) begin
        text_color <= cfg_wdata;
      end
      if (cmd_pop) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
        wr_ptr     <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (tcw_pkg::QPTR_W+1)'(cmd_pop) - (tcw_pkg::QPTR_W+1)'(do_pop);
    end
  end

  // Cursor never leaves the screen.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    CW'(cursor_col) < CW'(tcw_pkg::COLS))
    else $error("cursor column off screen");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    RW'(cursor_row) < RW'(tcw_pkg::ROWS))
    else $error("cursor row off screen");

  // A clear homes the cursor.
  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.op == tcw_pkg::OP_CLEAR) |=> (cursor_col == '0 && cursor_row == '0))
    else $error("clear did not home cursor");

  // Cursor moves only when a command executes.
  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd_pop |=> ($stable(cursor_col) && $stable(cursor_row)))
    else $error("cursor moved without a command");

endmodule

FILE: dv/tb_text_console_cell_writer_top.sv
// tb_text_console_cell_writer_top: self-checking testbench for the text console cell writer.
// Needs tcw_pkg and text_console_cell_writer_top; drives both queue ports and the color register.
// A cursor/cell model predicts every result not typed in; directed rows first, then three random phases.
module tb_text_console_cell_writer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  // Run length guard; the slowest legal run stays far below this.
  localparam int unsigned CYCLE_LIMIT = 300000;
  // A result can be popped once it has passed both queues; leave some slack.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int NDIR = 18;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  req_t req;
  logic empty;
  logic pop;
  res_t res;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  text_console_cell_writer_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req      (req),
    .empty    (empty),
    .pop      (pop),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 4 ns clock, high then low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cursor and color as the block should hold them
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [7:0]       text_color;

  // Results still owed by the block, oldest first.
  res_t due_results[$];

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  // Idle rates in percent and the long receiver hold-off, in cycles.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold_cycles = 0;

  // Works out the one result an item causes and moves the cursor.
  function automatic res_t predict_cell(input req_t r);
    res_t o;
    int col;
    int row;
    o = '0;
    col = cur_col;
    row = cur_row;
    case (r.req_type)
      REQ_CHAR: begin
        if (r.char_code == BACKSPACE_CHAR) begin
          // step back, wrapping to the end of the row above; home stays home
          if (col > 0) begin
            col--;
          end else if (row > 0) begin
            row--;
            col = COLS - 1;
          end
          o.cell_write = 1'b1;
          o.cell_index = ADDR_W'(row * COLS + col);
          o.cell_value = {text_color, BLANK_CHAR};
        end else if (r.char_code == NEWLINE_CHAR) begin
          col = 0;
          row++;
        end else begin
          o.cell_write = 1'b1;
          o.cell_index = ADDR_W'(row * COLS + col);
          o.cell_value = {text_color, r.char_code};
          col++;
        end
        if (col >= COLS) begin
          col = 0;
          row++;
        end
        if (row >= ROWS) row = 0;
      end
      REQ_CLEAR: begin
        o.fill_all = 1'b1;
        o.cell_value = {text_color, BLANK_CHAR};
        col = 0;
        row = 0;
      end
      REQ_AT: begin
        // off-screen positions give an all-zero result
        if (r.at_col < COLS && r.at_row < ROWS) begin
          o.cell_write = 1'b1;
          o.cell_index = ADDR_W'(r.at_row * COLS + r.at_col);
          o.cell_value = {r.at_color, r.char_code};
        end
      end
      default: begin
        o.cursor_valid = 1'b1;
        o.cursor_pos = ADDR_W'(row * COLS + col);
      end
    endcase
    cur_col = COL_W'(col);
    cur_row = ROW_W'(row);
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR result %0d: %s", results_seen, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows. Expected results are typed in where they are obvious from a
  // fresh reset (text color 0x0F); the rest go through the model.
  // ---------------------------------------------------------------------------
  typedef struct {
    req_t item;
    bit   typed;
    res_t want;
  } dir_row_t;

  dir_row_t dir_table [NDIR] = '{
    // end of string right after reset: cursor at home
    '{{REQ_EOS,   8'h00, 7'd0,   5'd0,  8'h00}, 1'b1, {1'b0, 1'b0, 11'd0,    16'h0000, 1'b1, 11'd0}},
    // backspace at home stays there and blanks cell 0
    '{{REQ_CHAR,  8'h08, 7'd0,   5'd0,  8'h00}, 1'b1, {1'b1, 1'b0, 11'd0,    16'h0F20, 1'b0, 11'd0}},
    // byte 0 is an ordinary character
    '{{REQ_CHAR,  8'h00, 7'd0,   5'd0,  8'h00}, 1'b1, {1'b1, 1'b0, 11'd0,    16'h0F00, 1'b0, 11'd0}},
    '{{REQ_CHAR,  8'hFF, 7'd127, 5'd31, 8'hFF}, 1'b1, {1'b1, 1'b0, 11'd1,    16'h0FFF, 1'b0, 11'd0}},
    // newline: no cell write, cursor to (0,1)
    '{{REQ_CHAR,  8'h0A, 7'd0,   5'd0,  8'h00}, 1'b1, {1'b0, 1'b0, 11'd0,    16'h0000, 1'b0, 11'd0}},
    '{{REQ_EOS,   8'hFF, 7'd127, 5'd31, 8'hFF}, 1'b1, {1'b0, 1'b0, 11'd0,    16'h0000, 1'b1, 11'd80}},
    // backspace at column 0 wraps to the last column of the row above
    '{{REQ_CHAR,  8'h08, 7'd0,   5'd0,  8'h00}, 1'b1, {1'b1, 1'b0, 11'd79,   16'h0F20, 1'b0, 11'd0}},
    // write in the last column wraps the cursor to the next row
    '{{REQ_CHAR,  8'h41, 7'd0,   5'd0,  8'h00}, 1'b1, {1'b1, 1'b0, 11'd79,   16'h0F41, 1'b0, 11'd0}},
    '{{REQ_EOS,   8'h00, 7'd0,   5'd0,  8'h00}, 1'b1, {1'b0, 1'b0, 11'd0,    16'h0000, 1'b1, 11'd80}},
    // positioned writes: last cell, first cell, off-screen column / row
    '{{REQ_AT,    8'hFF, 7'd79,  5'd24, 8'hFF}, 1'b1, {1'b1, 1'b0, 11'd1999, 16'hFFFF, 1'b0, 11'd0}},
    '{{REQ_AT,    8'h00, 7'd0,   5'd0,  8'h00}, 1'b1, {1'b1, 1'b0, 11'd0,    16'h0000, 1'b0, 11'd0}},
    '{{REQ_AT,    8'h55, 7'd80,  5'd0,  8'h33}, 1'b1, {1'b0, 1'b0, 11'd0,    16'h0000, 1'b0, 11'd0}},
    '{{REQ_AT,    8'hFF, 7'd127, 5'd31, 8'hFF}, 1'b1, {1'b0, 1'b0, 11'd0,    16'h0000, 1'b0, 11'd0}},
    '{{REQ_AT,    8'h41, 7'd0,   5'd25, 8'h12}, 1'b1, {1'b0, 1'b0, 11'd0,    16'h0000, 1'b0, 11'd0}},
    // backspace code as plain data in a positioned write
    '{{REQ_AT,    8'h08, 7'd5,   5'd3,  8'hA5}, 1'b1, {1'b1, 1'b0, 11'd245,  16'hA508, 1'b0, 11'd0}},
    // clear: fill with blanks and home the cursor
    '{{REQ_CLEAR, 8'hFF, 7'd127, 5'd31, 8'hFF}, 1'b1, {1'b0, 1'b1, 11'd0,    16'h0F20, 1'b0, 11'd0}},
    '{{REQ_CHAR,  8'h7E, 7'd9,   5'd9,  8'h99}, 1'b0, '0},
    '{{REQ_EOS,   8'h0A, 7'd64,  5'd16, 8'h80}, 1'b0, '0}
  };

  // Offer one item; called and returns on a falling edge. The expectation is
  // queued at offer time, which is safe since items are taken in order.
  task automatic send_item(input req_t r, input bit typed, input res_t want);
    res_t pred;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    pred = predict_cell(r);
    due_results.push_back(typed ? want : pred);
    push <= 1'b1;
    req <= r;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Let every owed result drain, then wait out the drain slack, before touching the
  // color register.
  task automatic write_text_color(input logic [7:0] color);
    push <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= color;
    @(negedge clk);
    cfg_we <= 1'b0;
    text_color = color;
  endtask

  // Mostly well-formed console traffic: printable runs, newlines, backspaces,
  // on-screen positioned writes and cursor reads, with the odd clear and
  // off-screen write mixed in.
  task automatic run_random_phase(input int unsigned n, input int unsigned tx_pct,
                                  input int unsigned rx_pct);
    req_t r;
    int unsigned pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) begin
      // every field random first, so unused bits toggle too
      r.req_type  = 2'($urandom_range(0, 3));
      r.char_code = 8'($urandom_range(0, 255));
      r.at_col    = 7'($urandom_range(0, 127));
      r.at_row    = 5'($urandom_range(0, 31));
      r.at_color  = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        r.req_type = REQ_CHAR;
        case ($urandom_range(0, 7))
          0: r.char_code = NEWLINE_CHAR;
          1: r.char_code = BACKSPACE_CHAR;
          2: r.char_code = 8'($urandom_range(32, 126));
          default: ;
        endcase
      end else if (pick < 61) begin
        r.req_type = REQ_CLEAR;
      end else if (pick < 84) begin
        r.req_type = REQ_AT;
        case ($urandom_range(0, 9))
          0: r.at_col = 7'($urandom_range(COLS, 127));
          1: r.at_row = 5'($urandom_range(ROWS, 31));
          default: begin
            r.at_col = 7'($urandom_range(0, COLS - 1));
            r.at_row = 5'($urandom_range(0, ROWS - 1));
          end
        endcase
      end else begin
        r.req_type = REQ_EOS;
      end
      send_item(r, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pops at a random rate; a pending hold-off keeps pop low for a
  // run of cycles so the queues fill and full rises.
  // ---------------------------------------------------------------------------
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (rx_hold_cycles > 0) begin
        pop <= 1'b0;
        rx_hold_cycles--;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Result checker: each popped result against the oldest expectation.
  always @(posedge clk) begin : check_result
    res_t want;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result 0x%h with nothing pending", res));
      end else begin
        want = due_results.pop_front();
        if (res.cell_write !== want.cell_write)
          report_mismatch($sformatf("cell_write %b, expected %b", res.cell_write,
                                    want.cell_write));
        if (res.fill_all !== want.fill_all)
          report_mismatch($sformatf("fill_all %b, expected %b", res.fill_all, want.fill_all));
        if (res.cell_index !== want.cell_index)
          report_mismatch($sformatf("cell_index %0d, expected %0d", res.cell_index,
                                    want.cell_index));
        if (res.cell_value !== want.cell_value)
          report_mismatch($sformatf("cell_value 0x%h, expected 0x%h", res.cell_value,
                                    want.cell_value));
        if (res.cursor_valid !== want.cursor_valid)
          report_mismatch($sformatf("cursor_valid %b, expected %b", res.cursor_valid,
                                    want.cursor_valid));
        if (res.cursor_pos !== want.cursor_pos)
          report_mismatch($sformatf("cursor_pos %0d, expected %0d", res.cursor_pos,
                                    want.cursor_pos));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_console_cell_writer_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    push = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = 8'h00;
    cur_col = '0;
    cur_row = '0;
    text_color = TEXT_COLOR_RST;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows at the reset color; sender 26 %, receiver 60 % idle.
    tx_idle_pct = 26;
    rx_idle_pct = 60;
    foreach (dir_table[k]) send_item(dir_table[k].item, dir_table[k].typed, dir_table[k].want);

    // Color at its low extreme, same idling.
    write_text_color(8'h00);
    run_random_phase(185, 26, 60);

    // High extreme, idling swapped.
    write_text_color(8'hFF);
    run_random_phase(185, 60, 26);

    // Random color, no idling; the receiver first sits out a long stretch
    // while the sender keeps pushing, so both queues fill and full rises.
    write_text_color(8'($urandom_range(1, 254)));
    rx_hold_cycles = 60;
    run_random_phase(180, 0, 0);

    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("text_console_cell_writer_top test passed");
    end else begin
      $display("text_console_cell_writer_top test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/tcw_pkg.sv
sv/tcw_front.sv
sv/tcw_back.sv
sv/text_console_cell_writer_top.sv
dv/tb_text_console_cell_writer_top.sv
